FILE: hdl/assert_macros.svh
// Assertion macros used by the port-level checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCTU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sctu assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SCTU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sctu assertion failed");

`endif

FILE: hdl/sctu_pkg.sv
// Types, constants and the rule function of the command-line tokenizer.
package sctu_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_BQUOTE = 8'h60;

  localparam logic [3:0] ERR_EOF  = 4'd0;
  localparam logic [3:0] ERR_CHAR = 4'd1;

  typedef enum logic [3:0] {
    KIND_NONE  = 4'd0,
    KIND_END   = 4'd1,
    KIND_ERROR = 4'd2,
    KIND_SPACE = 4'd3,
    KIND_FLAG  = 4'd5,
    KIND_LFLAG = 4'd6,
    KIND_VAR   = 4'd7,
    KIND_SQ    = 4'd8,
    KIND_DQ    = 4'd9,
    KIND_BQ    = 4'd10,
    KIND_ARG   = 4'd11
  } kind_t;

  typedef enum logic [3:0] {
    CLS_NUL,
    CLS_WS,
    CLS_DQ,
    CLS_SQ,
    CLS_BQ,
    CLS_DASH,
    CLS_DOLLAR,
    CLS_ALNUM,
    CLS_OTHER
  } char_class_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] sub;
  } scan_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        start;
    char_class_t cls;
  } queue_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    scan_t      st;
    logic [7:0] taken;
    logic       again;
  } rule_res_t;

  localparam scan_t SCAN_IDLE = '{kind: KIND_NONE, sub: 4'd0};

  function automatic rule_res_t apply_rule(scan_t st, char_class_t cls, logic [7:0] ch);
    rule_res_t res;
    logic      ok;
    logic      closing;
    res.st    = st;
    res.taken = 8'd0;
    res.again = 1'b0;
    ok        = 1'b0;
    closing   = 1'b0;
    unique case (st.kind)
      KIND_NONE: begin
        res.st.sub = 4'd0;
        res.again  = 1'b1;
        unique case (cls)
          CLS_NUL: begin
            res.st.kind = KIND_END;
            res.again   = 1'b0;
          end
          CLS_WS:     res.st.kind = KIND_SPACE;
          CLS_DQ:     res.st.kind = KIND_DQ;
          CLS_SQ:     res.st.kind = KIND_SQ;
          CLS_BQ:     res.st.kind = KIND_BQ;
          CLS_DASH:   res.st.kind = KIND_FLAG;
          CLS_DOLLAR: res.st.kind = KIND_VAR;
          default:    res.st.kind = KIND_ARG;
        endcase
      end
      KIND_SPACE: begin
        if (cls == CLS_WS) begin
          res.taken = ch;
        end else begin
          res.st    = SCAN_IDLE;
          res.again = 1'b1;
        end
      end
      KIND_ARG: begin
        if (cls == CLS_DQ || cls == CLS_SQ || cls == CLS_BQ || cls == CLS_DOLLAR ||
            cls == CLS_WS || cls == CLS_NUL) begin
          res.st    = SCAN_IDLE;
          res.again = 1'b1;
        end else begin
          res.taken = ch;
        end
      end
      KIND_SQ, KIND_DQ, KIND_BQ: begin
        closing = (st.kind == KIND_SQ && cls == CLS_SQ) ||
                  (st.kind == KIND_DQ && cls == CLS_DQ) ||
                  (st.kind == KIND_BQ && cls == CLS_BQ);
        priority if (st.sub == 4'd0) begin
          res.st.sub = 4'd1;
        end else if (closing) begin
          res.st = SCAN_IDLE;
        end else if (cls == CLS_NUL) begin
          res.st = '{kind: KIND_ERROR, sub: ERR_EOF};
        end else begin
          res.taken = ch;
        end
      end
      KIND_FLAG, KIND_LFLAG, KIND_VAR: begin
        ok = (cls == CLS_ALNUM) || (st.kind == KIND_LFLAG && cls == CLS_DASH);
        priority if (st.sub == 4'd0) begin
          res.st.sub = 4'd1;
        end else if (st.kind == KIND_FLAG && cls == CLS_DASH) begin
          res.st    = '{kind: KIND_LFLAG, sub: 4'd0};
          res.again = 1'b1;
        end else if (cls == CLS_NUL && st.sub < 4'd2) begin
          res.st = '{kind: KIND_ERROR, sub: ERR_EOF};
        end else if (!ok) begin
          res.again = 1'b1;
          if (st.sub < 4'd2) begin
            res.st = '{kind: KIND_ERROR, sub: ERR_CHAR};
          end else begin
            res.st = SCAN_IDLE;
          end
        end else begin
          if (st.sub < 4'd2) begin
            res.st.sub = st.sub + 4'd1;
          end
          res.taken = ch;
        end
      end
      default: begin
        res.again = 1'b0;
      end
    endcase
    return res;
  endfunction

endpackage

FILE: hdl/sctu_front.sv
// Front part: accepts input beats, classifies each byte and pushes it to the queue.
module sctu_front (
  input  logic                   rst,
  input  logic [7:0]             char_in,
  input  logic                   start_new,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  sctu_pkg::queue_status_t q_status,
  output logic                   push,
  output sctu_pkg::queue_entry_t push_entry
);
  import sctu_pkg::*;

  char_class_t cls;

  always_comb begin
    priority if (char_in == CH_NUL) begin
      cls = CLS_NUL;
    end else if (char_in == CH_SPACE || char_in == CH_TAB) begin
      cls = CLS_WS;
    end else if (char_in == CH_DQUOTE) begin
      cls = CLS_DQ;
    end else if (char_in == CH_SQUOTE) begin
      cls = CLS_SQ;
    end else if (char_in == CH_BQUOTE) begin
      cls = CLS_BQ;
    end else if (char_in == CH_DASH) begin
      cls = CLS_DASH;
    end else if (char_in == CH_DOLLAR) begin
      cls = CLS_DOLLAR;
    end else if ((char_in >= 8'h30 && char_in <= 8'h39) ||
                 (char_in >= 8'h41 && char_in <= 8'h5A) ||
                 (char_in >= 8'h61 && char_in <= 8'h7A)) begin
      cls = CLS_ALNUM;
    end else begin
      cls = CLS_OTHER;
    end
  end

  assign in_stall         = rst || q_status.full;
  assign push             = in_valid && !in_stall;
  assign push_entry.ch    = char_in;
  assign push_entry.start = start_new;
  assign push_entry.cls   = cls;

endmodule

FILE: hdl/sctu_queue.sv
// Short queue of classified bytes between the front and back parts.
module sctu_queue #(
  parameter int DEPTH = sctu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  sctu_pkg::queue_entry_t  push_entry,
  input  logic                    pop,
  output sctu_pkg::queue_entry_t  pop_entry,
  output sctu_pkg::queue_status_t status
);
  import sctu_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  queue_entry_t     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign pop_entry    = mem[rd_ptr];
  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);

endmodule

FILE: hdl/sctu_back.sv
// Back part: runs the scan rules on queued bytes and holds the result register.
module sctu_back (
  input  logic                    clk,
  input  logic                    rst,
  input  sctu_pkg::queue_status_t q_status,
  input  sctu_pkg::queue_entry_t  pop_entry,
  output logic                    pop,
  output logic [3:0]              token_kind,
  output logic [3:0]              sub_state,
  output logic [7:0]              taken_char,
  output logic                    out_valid,
  input  logic                    out_stall
);
  import sctu_pkg::*;

  scan_t     scan;
  scan_t     scan_in;
  rule_res_t r1;
  rule_res_t r2;
  rule_res_t r3;

  assign pop     = !q_status.empty && (!out_valid || !out_stall);
  assign scan_in = pop_entry.start ? SCAN_IDLE : scan;

  // A byte that ends a token is handed to the next rule; three rules cover every chain.
  always_comb begin
    r1 = apply_rule(scan_in, pop_entry.cls, pop_entry.ch);
    r2 = r1.again ? apply_rule(r1.st, pop_entry.cls, pop_entry.ch) : r1;
    r3 = r2.again ? apply_rule(r2.st, pop_entry.cls, pop_entry.ch) : r2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan      <= SCAN_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        scan      <= r3.st;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      token_kind <= r3.st.kind;
      sub_state  <= r3.st.sub;
      taken_char <= r3.taken;
    end
  end

endmodule

FILE: hdl/shell_command_tokenizer_unit.sv
// Shell command-line tokenizer: one byte in, one scan result out per beat. The block
// takes a byte every cycle unless in_stall is high (in reset or with the queue full)
// and delivers one result per byte, through the queue and then the result register.
// The front part classifies the byte and writes it to a short queue; the back part
// updates the 8-bit scan state, resolving up to three chained rules combinationally,
// and the feedback of that state is what sets the one-byte-per-cycle rate. The queue
// lets input keep flowing for a few beats while the output is stalled.
module shell_command_tokenizer_unit #(
  parameter int QUEUE_DEPTH = sctu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_in,
  input  logic       start_new,
  input  logic       in_valid,
  output logic       in_stall,
  output logic [3:0] token_kind,
  output logic [3:0] sub_state,
  output logic [7:0] taken_char,
  output logic       out_valid,
  input  logic       out_stall
);
  import sctu_pkg::*;

  queue_status_t q_status;
  queue_entry_t  push_entry;
  queue_entry_t  pop_entry;
  logic          push;
  logic          pop;

  sctu_front u_front (
    .rst        (rst),
    .char_in    (char_in),
    .start_new  (start_new),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  sctu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .status     (q_status)
  );

  sctu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .pop_entry  (pop_entry),
    .pop        (pop),
    .token_kind (token_kind),
    .sub_state  (sub_state),
    .taken_char (taken_char),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

endmodule

FILE: hdl/sctu_checker.sv
// Port-level checker for the tokenizer and its bind to the top level.
`include "assert_macros.svh"

module sctu_checker (
  input logic       clk,
  input logic       rst,
  input logic [3:0] token_kind,
  input logic [3:0] sub_state,
  input logic [7:0] taken_char,
  input logic       out_valid,
  input logic       out_stall
);
  import sctu_pkg::*;

  `SCTU_ASSERT_NXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(token_kind) && $stable(sub_state) && $stable(taken_char))

  `SCTU_ASSERT_IMP(a_error_code, out_valid && token_kind == KIND_ERROR,
    sub_state == ERR_EOF || sub_state == ERR_CHAR)

  `SCTU_ASSERT_IMP(a_taken_kind, out_valid && taken_char != 8'd0,
    token_kind == KIND_SPACE || token_kind == KIND_FLAG || token_kind == KIND_LFLAG ||
    token_kind == KIND_VAR || token_kind == KIND_SQ || token_kind == KIND_DQ ||
    token_kind == KIND_BQ || token_kind == KIND_ARG)

  `SCTU_ASSERT_IMP(a_space_taken, out_valid && token_kind == KIND_SPACE,
    taken_char == CH_SPACE || taken_char == CH_TAB)

endmodule

bind shell_command_tokenizer_unit sctu_checker u_checker (.*);

FILE: sim/tokenizer_checker.sv
`timescale 1ns / 100ps
// Checker for the command-line tokenizer: predicts every result beat and compares it.
module tokenizer_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_in,
  input  logic       start_new,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [3:0] token_kind,
  input  logic [3:0] sub_state,
  input  logic [7:0] taken_char,
  input  logic       out_valid,
  input  logic       out_stall,
  output int         mismatch_count,
  output int         open_beats
);
  import sctu_pkg::*;

  typedef struct packed {
    logic [3:0] kind;
    logic [3:0] sub;
    logic [7:0] grab;
    logic       more;
  } rule_out_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [3:0] sub;
    logic [7:0] grab;
  } token_beat_t;

  logic [3:0]  scan_kind = KIND_NONE;
  logic [3:0]  scan_sub = 4'd0;
  token_beat_t token_beats_q[$];

  function automatic logic is_word_byte(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic rule_out_t apply_token_rule(logic [3:0] kind, logic [3:0] sub,
                                                 logic [7:0] c);
    rule_out_t  r;
    logic [7:0] closer;
    logic       fits;
    r.kind = kind;
    r.sub  = sub;
    r.grab = 8'd0;
    r.more = 1'b0;
    case (kind)
      KIND_NONE: begin
        r.sub  = 4'd0;
        r.more = 1'b1;
        if (c == CH_NUL) begin
          r.kind = KIND_END;
          r.more = 1'b0;
        end else if (c == CH_SPACE || c == CH_TAB) begin
          r.kind = KIND_SPACE;
        end else if (c == CH_DQUOTE) begin
          r.kind = KIND_DQ;
        end else if (c == CH_SQUOTE) begin
          r.kind = KIND_SQ;
        end else if (c == CH_BQUOTE) begin
          r.kind = KIND_BQ;
        end else if (c == CH_DASH) begin
          r.kind = KIND_FLAG;
        end else if (c == CH_DOLLAR) begin
          r.kind = KIND_VAR;
        end else begin
          r.kind = KIND_ARG;
        end
      end
      KIND_SPACE: begin
        if (c == CH_SPACE || c == CH_TAB) begin
          r.grab = c;
        end else begin
          r.kind = KIND_NONE;
          r.sub  = 4'd0;
          r.more = 1'b1;
        end
      end
      KIND_ARG: begin
        if (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BQUOTE || c == CH_DOLLAR ||
            c == CH_SPACE || c == CH_TAB || c == CH_NUL) begin
          r.kind = KIND_NONE;
          r.sub  = 4'd0;
          r.more = 1'b1;
        end else begin
          r.grab = c;
        end
      end
      KIND_SQ, KIND_DQ, KIND_BQ: begin
        closer = (kind == KIND_SQ) ? CH_SQUOTE : (kind == KIND_DQ) ? CH_DQUOTE : CH_BQUOTE;
        if (sub == 4'd0) begin
          r.sub = 4'd1;
        end else if (c == closer) begin
          r.kind = KIND_NONE;
          r.sub  = 4'd0;
        end else if (c == CH_NUL) begin
          r.kind = KIND_ERROR;
          r.sub  = ERR_EOF;
        end else begin
          r.grab = c;
        end
      end
      KIND_FLAG, KIND_LFLAG, KIND_VAR: begin
        fits = is_word_byte(c) || (kind == KIND_LFLAG && c == CH_DASH);
        if (sub == 4'd0) begin
          r.sub = 4'd1;
        end else if (kind == KIND_FLAG && c == CH_DASH) begin
          r.kind = KIND_LFLAG;
          r.sub  = 4'd0;
          r.more = 1'b1;
        end else if (c == CH_NUL && sub < 4'd2) begin
          r.kind = KIND_ERROR;
          r.sub  = ERR_EOF;
        end else if (!fits) begin
          r.more = 1'b1;
          if (sub < 4'd2) begin
            r.kind = KIND_ERROR;
            r.sub  = ERR_CHAR;
          end else begin
            r.kind = KIND_NONE;
            r.sub  = 4'd0;
          end
        end else begin
          if (sub < 4'd2) begin
            r.sub = sub + 4'd1;
          end
          r.grab = c;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic token_beat_t scan_byte(logic [3:0] kind, logic [3:0] sub,
                                            logic [7:0] c, logic restart);
    token_beat_t b;
    rule_out_t   r;
    if (restart) begin
      kind = KIND_NONE;
      sub  = 4'd0;
    end
    b.grab = 8'd0;
    for (int i = 0; i < 4; i++) begin
      r = apply_token_rule(kind, sub, c);
      kind = r.kind;
      sub  = r.sub;
      b.grab = r.grab;
      if (!r.more) break;
    end
    b.kind = kind;
    b.sub  = sub;
    return b;
  endfunction

  always @(posedge clk) begin
    token_beat_t want;
    int          bad;
    bad = 0;
    if (rst) begin
      scan_kind <= KIND_NONE;
      scan_sub <= 4'd0;
      token_beats_q.delete();
      open_beats <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        want = scan_byte(scan_kind, scan_sub, char_in, start_new);
        scan_kind <= want.kind;
        scan_sub <= want.sub;
        token_beats_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (token_beats_q.size() == 0) begin
          $display("%0t: unexpected result beat: kind %0d, sub-state %0d, byte %0d",
                   $time, token_kind, sub_state, taken_char);
          bad = 1;
        end else begin
          want = token_beats_q.pop_front();
          if (token_kind !== want.kind) begin
            $display("%0t: token_kind expected %0d, actual %0d", $time, want.kind, token_kind);
            bad++;
          end
          if (sub_state !== want.sub) begin
            $display("%0t: sub_state expected %0d, actual %0d", $time, want.sub, sub_state);
            bad++;
          end
          if (taken_char !== want.grab) begin
            $display("%0t: taken_char expected 0x%02h, actual 0x%02h", $time, want.grab,
                     taken_char);
            bad++;
          end
        end
      end
      mismatch_count <= mismatch_count + bad;
      open_beats <= token_beats_q.size();
    end
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// Top of the tokenizer testbench: clock, reset, byte stimulus, output stalls and verdict.
module testbench;
  import sctu_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int BYTE_BUDGET = 1375;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] char_in = 8'd0;
  logic       start_new = 1'b0;
  logic       in_valid = 1'b0;
  logic       out_stall = 1'b0;
  wire        in_stall;
  wire        out_valid;
  wire  [3:0] token_kind;
  wire  [3:0] sub_state;
  wire  [7:0] taken_char;

  int mismatch_count;
  int open_beats;
  int cycle_count = 0;
  int beats_sent = 0;
  bit calm = 1'b0;
  bit fresh_line = 1'b0;

  shell_command_tokenizer_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_in),
    .start_new (start_new),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .token_kind(token_kind),
    .sub_state (sub_state),
    .taken_char(taken_char),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  tokenizer_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .char_in       (char_in),
    .start_new     (start_new),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .token_kind    (token_kind),
    .sub_state     (sub_state),
    .taken_char    (taken_char),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .mismatch_count(mismatch_count),
    .open_beats    (open_beats)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      out_stall <= !calm && ($urandom_range(99) < 31);
    end
  end

  function automatic logic [7:0] word_byte();
    int k;
    k = $urandom_range(61);
    if (k < 10) return 8'("0" + k);
    if (k < 36) return 8'("a" + k - 10);
    return 8'("A" + k - 36);
  endfunction

  function automatic logic [7:0] plain_byte(logic body);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BQUOTE || c == CH_DOLLAR ||
               c == CH_SPACE || c == CH_TAB || (!body && c == CH_DASH));
    return c;
  endfunction

  function automatic logic [7:0] quoted_byte(logic [7:0] q);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == q);
    return c;
  endfunction

  task automatic push_byte(input logic [7:0] c);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    char_in <= c;
    start_new <= fresh_line;
    in_valid <= 1'b1;
    fresh_line = 1'b0;
    beats_sent++;
    calm = (beats_sent >= 500 && beats_sent < 750);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_run(input int n, input logic with_dash);
    repeat (n) begin
      if (with_dash && $urandom_range(4) == 0) push_byte(CH_DASH);
      else push_byte(word_byte());
    end
  endtask

  task automatic send_line();
    logic [7:0] q;
    fresh_line = 1'b1;
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(9))
        0, 1: begin
          push_byte(plain_byte(1'b0));
          repeat ($urandom_range(5)) push_byte(plain_byte(1'b1));
        end
        2: begin
          push_byte(CH_DASH);
          send_run($urandom_range(4), 1'b0);
        end
        3: begin
          push_byte(CH_DASH);
          push_byte(CH_DASH);
          send_run($urandom_range(6), 1'b1);
        end
        4: begin
          push_byte(CH_DOLLAR);
          send_run($urandom_range(5), 1'b0);
        end
        5, 6, 7: begin
          case ($urandom_range(2))
            0: q = CH_SQUOTE;
            1: q = CH_DQUOTE;
            default: q = CH_BQUOTE;
          endcase
          push_byte(q);
          repeat ($urandom_range(6)) push_byte(quoted_byte(q));
          if ($urandom_range(9) != 0) push_byte(q);
        end
        8: repeat ($urandom_range(1, 3)) push_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
        default: push_byte(8'($urandom_range(255)));
      endcase
      if ($urandom_range(3) != 0) push_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
    end
    if ($urandom_range(9) != 0) push_byte(CH_NUL);
  endtask

  initial begin
    string lead;
    lead = "-a --x $v'q'\"d\"`b`w";
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    fresh_line = 1'b1;
    for (int i = 0; i < lead.len(); i++) push_byte(lead[i]);
    push_byte(8'hFF);
    push_byte(CH_TAB);
    push_byte(CH_NUL);
    push_byte("z");
    fresh_line = 1'b1;
    push_byte(CH_DASH);
    push_byte(CH_NUL);
    push_byte(8'h80);

    while (beats_sent < BYTE_BUDGET) begin
      if ($urandom_range(9) < 8) begin
        send_line();
      end else begin
        repeat ($urandom_range(1, 10)) begin
          fresh_line = ($urandom_range(9) == 0);
          push_byte(8'($urandom_range(255)));
        end
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (open_beats != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/sctu_pkg.sv
hdl/sctu_front.sv
hdl/sctu_queue.sv
hdl/sctu_back.sv
hdl/shell_command_tokenizer_unit.sv
hdl/sctu_checker.sv
sim/tokenizer_checker.sv
sim/testbench.sv
